/* rtl/core/ehc_pkg.sv */
// Shared constants, command struct and match table for the extension hash classifier.
package ehc_pkg;

    localparam int CHAR_BITS  = 16;
    localparam int HASH_BITS  = 64;
    localparam int HALF_BITS  = HASH_BITS / 2;
    localparam int STEP_SHIFT = 16;   // 65537 = 2^16 + 1
    localparam int MUL_BITS   = 30;
    localparam int PROD_BITS  = HALF_BITS + MUL_BITS;
    localparam int IDX_BITS   = 4;

    localparam logic [MUL_BITS-1:0]  FINAL_MUL   = 30'h20026eba;
    localparam logic [CHAR_BITS-1:0] PERIOD_CODE = CHAR_BITS'(8'h2e);

    typedef struct packed {
        logic absorb;     // fold the accepted character into the hash
        logic mul_lo;     // multiply the low half of the hash
        logic mul_hi;     // multiply the high half of the hash
        logic mix;        // combine partial products and fold the high half down
        logic load_out;   // compare with the table, load the result, clear the hash
    } ehc_cmd_t;

    function automatic logic [HASH_BITS-1:0] match_entry(input logic [IDX_BITS-1:0] idx);
        logic [HASH_BITS-1:0] entry;
        unique case (idx)
            4'd0:    entry = 64'hffffe0068e0d5590;
            4'd1:    entry = 64'hffffe0052e196bf1;
            4'd2:    entry = 64'he0063200998a4042;
            4'd3:    entry = 64'hffffe0072df29793;
            4'd4:    entry = 64'he00a3256b1621294;
            4'd5:    entry = 64'he007921dfba97d35;
            4'd6:    entry = 64'he005b1f45e783756;
            4'd7:    entry = 64'h9255e8d39e48ad27;
            4'd8:    entry = 64'he009b24a76508768;
            4'd9:    entry = 64'h91fc109d148fd0a9;
            4'd10:   entry = 64'he00b927213810fda;
            4'd11:   entry = 64'h3263528dcd0e3d1b;
            4'd12:   entry = 64'hffffe00a8dbf6cdc;
            4'd13:   entry = 64'hffffe0092dcb833d;
            4'd14:   entry = 64'h32097a584aca938e;
            default: entry = 64'hffffe00b2da4aedf;
        endcase
        return entry;
    endfunction

endpackage

/* rtl/core/ehc_ctrl.sv */
// Controller state machine that sequences character absorption and hash finalization.
module ehc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_unit,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output ehc_pkg::ehc_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MIX,
        S_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.absorb = 1'b1;
                    if (last_unit)
                    begin
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // Hold here until the output register can take the new flag.
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/ehc_datapath.sv */
// Datapath holding the running hash, the shared finalization multiplier and the result flag.
module ehc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ehc_pkg::ehc_cmd_t            cmd,
    input  logic [ehc_pkg::CHAR_BITS-1:0] code_unit,
    output logic                         is_source
);

    logic [ehc_pkg::HASH_BITS-1:0] hash_reg;
    logic [ehc_pkg::HASH_BITS-1:0] hash_next;
    logic [ehc_pkg::PROD_BITS-1:0] prod_reg;
    logic [ehc_pkg::HALF_BITS-1:0] part_reg;
    logic [ehc_pkg::HASH_BITS-1:0] mix_reg;
    logic [ehc_pkg::HASH_BITS-1:0] mix_next;
    logic [ehc_pkg::HASH_BITS-1:0] sum;
    logic                          is_source_reg;
    logic [ehc_pkg::HALF_BITS-1:0] mul_a;
    logic [ehc_pkg::PROD_BITS-1:0] mul_p;

    // A period restarts the hash at all ones; anything else is h * 65537 + c.
    always_comb
    begin
        if (code_unit == ehc_pkg::PERIOD_CODE)
        begin
            hash_next = '1;
        end
        else
        begin
            hash_next = hash_reg + (hash_reg << ehc_pkg::STEP_SHIFT)
                      + ehc_pkg::HASH_BITS'(code_unit);
        end
    end

    // One 32 x 30 multiplier serves both halves of the hash.
    assign mul_a = cmd.mul_hi ? hash_reg[ehc_pkg::HASH_BITS-1:ehc_pkg::HALF_BITS]
                              : hash_reg[ehc_pkg::HALF_BITS-1:0];
    assign mul_p = ehc_pkg::PROD_BITS'(mul_a) * ehc_pkg::PROD_BITS'(ehc_pkg::FINAL_MUL);

    assign sum      = ehc_pkg::HASH_BITS'(prod_reg) + {part_reg, {ehc_pkg::HALF_BITS{1'b0}}};
    assign mix_next = sum ^ (sum >> ehc_pkg::HALF_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else if (cmd.absorb)
        begin
            hash_reg <= hash_next;
        end
        else if (cmd.load_out)
        begin
            hash_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_hi)
        begin
            part_reg <= mul_p[ehc_pkg::HALF_BITS-1:0];
        end
        if (cmd.mix)
        begin
            mix_reg <= mix_next;
        end
        if (cmd.load_out)
        begin
            is_source_reg <= (ehc_pkg::match_entry(mix_reg[ehc_pkg::IDX_BITS-1:0]) == mix_reg);
        end
    end

    assign is_source = is_source_reg;

endmodule

/* rtl/core/extension_hash_classifier.sv */
// Top level of the extension hash classifier: controller plus datapath.
//
//  Channel | Handshake           | Payload                  | Direction
//  --------+---------------------+--------------------------+----------
//  input   | in_valid / in_stall | code_unit[15:0], last_unit | in
//  output  | out_valid/out_stall | is_source                | out
//
// A character that is not the last of its name is absorbed straight into the running hash,
// so such characters stream at one transfer per cycle while no earlier name is in finalization.
// After the last character is absorbed, the controller steps through finalization: the
// shared 32 x 30 multiplier takes the low half, then the high half of the hash, a step
// sums and folds the hash, and a last step compares it with the match table and loads
// the output register. Reset clears the controller and the running hash; the block
// accepts characters as soon as reset is released. The output register holds its flag
// until the transfer completes, and the next name streams in meanwhile; only a second
// finished flag waits in the compare step while the previous one is still stalled.
module extension_hash_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ehc_pkg::CHAR_BITS-1:0] code_unit,
    input  logic                          last_unit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_source
);

    ehc_pkg::ehc_cmd_t cmd;

    // The controller decides when each character is taken and steps finalization.
    ehc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_unit (last_unit),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath keeps the running hash and produces the classification flag.
    ehc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .code_unit (code_unit),
        .is_source (is_source)
    );

endmodule
